>>> sv/kpd_pkg.sv
// Package for the keypad press/hold detector.
// Holds the item and result types, operation and state codes and the key decode.
// No dependencies.
package kpd_pkg;

	localparam int LINE_W = 3;
	localparam int KEY_W = 6;
	localparam int OP_W = 2;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DEB_W = 8;
	localparam int TIME_W = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_PAD = 2'd1;
	localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;

	// Press state codes; clicked and held double as the reported event kind.
	localparam logic [KIND_W-1:0] PS_NONE = 2'd0;
	localparam logic [KIND_W-1:0] PS_CLICKED = 2'd1;
	localparam logic [KIND_W-1:0] PS_HELD = 2'd2;
	localparam logic [KIND_W-1:0] PS_PRESSED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD = 2'd1;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd10;
	localparam logic [TIME_W-1:0] HOLD_RESET = 16'd1000;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [LINE_W-1:0] row_lines;
		logic [LINE_W-1:0] col_lines;
	} item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_code;
		logic [KIND_W-1:0] event_kind;
	} result_t;

	// A key needs at least one row line and one column line.
	function automatic logic [KEY_W-1:0] key_from_lines(
		input logic [LINE_W-1:0] rows,
		input logic [LINE_W-1:0] cols
	);
		logic [KEY_W-1:0] k;
		begin
			if (rows == '0 || cols == '0) begin
				k = '0;
			end else begin
				k = {cols, rows};
			end
			return k;
		end
	endfunction

endpackage

>>> sv/kpd_in_reg.sv
// Input register stage of the keypad press/hold detector.
// Captures one word per cycle unless stalled, and holds a consume word while the result register is busy.
// Depends on kpd_pkg.
module kpd_in_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [kpd_pkg::OP_W-1:0] op,
	input  logic [kpd_pkg::LINE_W-1:0] row_lines,
	input  logic [kpd_pkg::LINE_W-1:0] col_lines,
	input  logic out_busy,
	output kpd_pkg::item_t item_s1,
	output logic fire_s1
);

	logic valid_s1;
	logic advance;

	// Only a consume request needs room in the result register.
	assign advance = !(item_s1.op == kpd_pkg::OP_CONSUME && out_busy);
	assign fire_s1 = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.op <= op;
			item_s1.row_lines <= row_lines;
			item_s1.col_lines <= col_lines;
		end
	end

endmodule

>>> sv/kpd_core.sv
// Press state, timers and configuration registers of the keypad detector.
// Applies one word from the input stage per cycle while that stage is not stalled, and forms the consume result.
// Depends on kpd_pkg.
module kpd_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kpd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  kpd_pkg::item_t item_s1,
	input  logic fire_s1,
	output kpd_pkg::result_t result
);

	logic [kpd_pkg::DEB_W-1:0] debounce_q;
	logic [kpd_pkg::TIME_W-1:0] hold_ms_q;
	logic [kpd_pkg::KIND_W-1:0] state_q, state_d;
	logic [kpd_pkg::KEY_W-1:0] pressed_key_q, pressed_key_d;
	logic [kpd_pkg::TIME_W-1:0] event_age_q, event_age_d;
	logic [kpd_pkg::TIME_W-1:0] hold_timer_q, hold_timer_d, timer_inc;
	logic hold_running_q, hold_running_d;
	logic [kpd_pkg::KEY_W-1:0] key;
	logic ready_now;

	assign cfg_ready = 1'b1;
	assign key = kpd_pkg::key_from_lines(item_s1.row_lines, item_s1.col_lines);
	assign ready_now = (state_q == kpd_pkg::PS_CLICKED) || (state_q == kpd_pkg::PS_HELD);
	assign timer_inc = (hold_timer_q != kpd_pkg::TIME_MAX) ? hold_timer_q + 16'd1 : hold_timer_q;

	always_comb begin
		result.key_code = ready_now ? pressed_key_q : '0;
		result.event_kind = ready_now ? state_q : kpd_pkg::PS_NONE;
	end

	always_comb begin
		state_d = state_q;
		pressed_key_d = pressed_key_q;
		event_age_d = event_age_q;
		hold_timer_d = hold_timer_q;
		hold_running_d = hold_running_q;
		if (fire_s1) begin
			unique case (item_s1.op)
				kpd_pkg::OP_TICK: begin
					if (event_age_q != kpd_pkg::TIME_MAX) begin
						event_age_d = event_age_q + 16'd1;
					end
					if (hold_running_q) begin
						hold_timer_d = timer_inc;
						if (timer_inc >= hold_ms_q) begin
							hold_running_d = 1'b0;
							hold_timer_d = '0;
							if (state_q == kpd_pkg::PS_PRESSED && pressed_key_q == key) begin
								state_d = kpd_pkg::PS_HELD;
							end else begin
								state_d = kpd_pkg::PS_NONE;
								pressed_key_d = '0;
							end
						end
					end
				end
				kpd_pkg::OP_PAD: begin
					// Events inside the debounce window are dropped.
					if (event_age_q >= {8'd0, debounce_q}) begin
						event_age_d = '0;
						if (key == '0) begin
							hold_running_d = 1'b0;
							if (state_q == kpd_pkg::PS_PRESSED) begin
								state_d = kpd_pkg::PS_CLICKED;
							end
						end else begin
							pressed_key_d = key;
							state_d = kpd_pkg::PS_PRESSED;
							hold_timer_d = '0;
							hold_running_d = 1'b1;
						end
					end
				end
				kpd_pkg::OP_CONSUME: begin
					if (ready_now) begin
						state_d = kpd_pkg::PS_NONE;
						pressed_key_d = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= kpd_pkg::DEBOUNCE_RESET;
			hold_ms_q <= kpd_pkg::HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == kpd_pkg::REG_DEBOUNCE) begin
				debounce_q <= cfg_data[kpd_pkg::DEB_W-1:0];
			end else if (cfg_index == kpd_pkg::REG_HOLD) begin
				hold_ms_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kpd_pkg::PS_NONE;
			pressed_key_q <= '0;
			event_age_q <= '0;
			hold_timer_q <= '0;
			hold_running_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pressed_key_q <= pressed_key_d;
			event_age_q <= event_age_d;
			hold_timer_q <= hold_timer_d;
			hold_running_q <= hold_running_d;
		end
	end

	// The hold timer only runs for a press that has not been resolved.
	a_running_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		hold_running_q |-> state_q == kpd_pkg::PS_PRESSED)
		else $error("hold timer running outside pressed state");

	a_none_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kpd_pkg::PS_NONE |-> pressed_key_q == '0)
		else $error("key kept with no press pending");

	a_active_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != kpd_pkg::PS_NONE |-> pressed_key_q != '0)
		else $error("press pending with empty key");

	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && item_s1.op == kpd_pkg::OP_CONSUME && ready_now)
		|=> (state_q == kpd_pkg::PS_NONE && pressed_key_q == '0))
		else $error("reported event not cleared");

endmodule

>>> sv/kpd_out_reg.sv
// Result register of the keypad press/hold detector.
// Holds one consume result until the downstream side takes it.
// Depends on kpd_pkg.
module kpd_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  kpd_pkg::result_t result,
	output logic out_busy,
	output logic out_valid,
	input  logic out_stall,
	output logic [kpd_pkg::KEY_W-1:0] key_code,
	output logic [kpd_pkg::KIND_W-1:0] event_kind
);

	logic valid_q;
	kpd_pkg::result_t result_q;

	assign out_busy = valid_q && out_stall;
	assign out_valid = valid_q;
	assign key_code = result_q.key_code;
	assign event_kind = result_q.event_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

>>> sv/keypad_matrix_press_hold_detector.sv
// Top level of the keypad press/hold detector for a 3x3 key matrix.
// Depends on kpd_pkg, kpd_in_reg, kpd_core and kpd_out_reg.
//
//   channel  handshake             payload
//   input    in_valid / in_stall   op, row_lines, col_lines
//   output   out_valid / out_stall key_code, event_kind
//   config   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One word is taken per cycle unless stalled. A consume result is loaded from the input
// register into the result register. A consume that finds an untaken result there waits
// in the input register, and the input stalls for every word until that result is taken.
// Reset clears the press state, timers and valid flags and restores the config defaults.
// The config port is always ready.
module keypad_matrix_press_hold_detector (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [kpd_pkg::OP_W-1:0] op,
	input  logic [kpd_pkg::LINE_W-1:0] row_lines,
	input  logic [kpd_pkg::LINE_W-1:0] col_lines,
	output logic out_valid,
	input  logic out_stall,
	output logic [kpd_pkg::KEY_W-1:0] key_code,
	output logic [kpd_pkg::KIND_W-1:0] event_kind,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kpd_pkg::CFG_DATA_W-1:0] cfg_data
);

	kpd_pkg::item_t item_s1;
	kpd_pkg::result_t result;
	logic fire_s1;
	logic out_busy;
	logic load;

	assign load = fire_s1 && item_s1.op == kpd_pkg::OP_CONSUME;

	kpd_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.row_lines(row_lines),
		.col_lines(col_lines),
		.out_busy(out_busy),
		.item_s1(item_s1),
		.fire_s1(fire_s1)
	);

	kpd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_s1(item_s1),
		.fire_s1(fire_s1),
		.result(result)
	);

	kpd_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.result(result),
		.out_busy(out_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_code(key_code),
		.event_kind(event_kind)
	);

endmodule

>>> verif/tb.sv
// Self-checking testbench for keypad_matrix_press_hold_detector.
// Holds a press/hold classifier that tracks the block's state and checks each consume report.
// Depends on kpd_pkg and the keypad_matrix_press_hold_detector RTL.
`timescale 1ns / 1ps

module tb;

	// Op value with no meaning; the block ignores such a word.
	localparam logic [kpd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	// Tracks debounce, hold timing and the pending key, and keeps the reports still due.
	class press_classifier;
		logic [kpd_pkg::DEB_W-1:0] debounce;
		logic [kpd_pkg::TIME_W-1:0] hold_lim;
		logic [kpd_pkg::KIND_W-1:0] state;
		logic [kpd_pkg::KEY_W-1:0] key_held;
		logic [kpd_pkg::TIME_W-1:0] age;
		logic [kpd_pkg::TIME_W-1:0] timer;
		bit running;
		kpd_pkg::result_t due[$];
		int fails;

		function new();
			debounce = kpd_pkg::DEBOUNCE_RESET;
			hold_lim = kpd_pkg::HOLD_RESET;
			state = kpd_pkg::PS_NONE;
			key_held = '0;
			age = '0;
			timer = '0;
			running = 0;
			fails = 0;
		endfunction

		function void set_register(logic [kpd_pkg::CFG_IDX_W-1:0] idx,
			logic [kpd_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				kpd_pkg::REG_DEBOUNCE: begin
					debounce = val[kpd_pkg::DEB_W-1:0];
				end
				kpd_pkg::REG_HOLD: begin
					hold_lim = val[kpd_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void take_word(kpd_pkg::item_t w);
			logic [kpd_pkg::KEY_W-1:0] k;
			kpd_pkg::result_t r;
			k = '0;
			if (w.row_lines != '0 && w.col_lines != '0) begin
				k = {w.col_lines, w.row_lines};
			end
			case (w.op)
				kpd_pkg::OP_TICK: begin
					if (age != kpd_pkg::TIME_MAX) begin
						age = age + 16'd1;
					end
					if (running) begin
						if (timer != kpd_pkg::TIME_MAX) begin
							timer = timer + 16'd1;
						end
						if (timer >= hold_lim) begin
							running = 0;
							timer = '0;
							// Only the same key still down on the expiring tick makes a hold.
							if (state == kpd_pkg::PS_PRESSED && key_held == k) begin
								state = kpd_pkg::PS_HELD;
							end else begin
								state = kpd_pkg::PS_NONE;
								key_held = '0;
							end
						end
					end
				end
				kpd_pkg::OP_PAD: begin
					if (age >= {8'd0, debounce}) begin
						age = '0;
						if (k == '0) begin
							running = 0;
							if (state == kpd_pkg::PS_PRESSED) begin
								state = kpd_pkg::PS_CLICKED;
							end
						end else begin
							key_held = k;
							state = kpd_pkg::PS_PRESSED;
							timer = '0;
							running = 1;
						end
					end
				end
				kpd_pkg::OP_CONSUME: begin
					if (state == kpd_pkg::PS_CLICKED || state == kpd_pkg::PS_HELD) begin
						r.key_code = key_held;
						r.event_kind = state;
						state = kpd_pkg::PS_NONE;
						key_held = '0;
					end else begin
						r.key_code = '0;
						r.event_kind = kpd_pkg::PS_NONE;
					end
					due.push_back(r);
				end
				default: begin
				end
			endcase
		endfunction

		function void match_report(kpd_pkg::result_t got);
			kpd_pkg::result_t exp;
			if (due.size() == 0) begin
				fails++;
				$display("%0t: unexpected report, expected none, got key %0d kind %0d",
					$time, got.key_code, got.event_kind);
			end else begin
				exp = due.pop_front();
				if (got.key_code !== exp.key_code) begin
					fails++;
					$display("%0t: key_code expected %0d, got %0d",
						$time, exp.key_code, got.key_code);
				end
				if (got.event_kind !== exp.event_kind) begin
					fails++;
					$display("%0t: event_kind expected %0d, got %0d",
						$time, exp.event_kind, got.event_kind);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [kpd_pkg::OP_W-1:0] op;
	logic [kpd_pkg::LINE_W-1:0] row_lines;
	logic [kpd_pkg::LINE_W-1:0] col_lines;
	logic out_valid;
	logic out_stall;
	logic [kpd_pkg::KEY_W-1:0] key_code;
	logic [kpd_pkg::KIND_W-1:0] event_kind;
	logic cfg_valid;
	logic cfg_ready;
	logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kpd_pkg::CFG_DATA_W-1:0] cfg_data;

	press_classifier classifier;
	bit steady;
	int sink_wait;
	int words_sent;
	int cur_deb;
	int cur_hold;

	keypad_matrix_press_hold_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.row_lines(row_lines),
		.col_lines(col_lines),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_code(key_code),
		.event_kind(event_kind),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(800_000 * 12);
		$display("** keypad_matrix_press_hold_detector: FAILED **");
		$finish;
	end

	function automatic int draw_gap();
		if (steady) begin
			return 0;
		end
		return int'($urandom_range(15, 0));
	endfunction

	function automatic logic [kpd_pkg::LINE_W-1:0] rand_lines(input int unsigned lo);
		logic [31:0] v;
		v = $urandom_range(7, lo);
		return v[kpd_pkg::LINE_W-1:0];
	endfunction

	function automatic logic [kpd_pkg::OP_W-1:0] rand_op();
		logic [31:0] v;
		v = $urandom_range(3, 0);
		return v[kpd_pkg::OP_W-1:0];
	endfunction

	// Receiver: checks each report taken, then may hold stall high for a random gap.
	initial begin
		kpd_pkg::result_t got;
		out_stall = 1'b0;
		sink_wait = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.key_code = key_code;
				got.event_kind = event_kind;
				classifier.match_report(got);
				sink_wait = draw_gap();
			end
			@(negedge clk);
			if (sink_wait > 0) begin
				out_stall = 1'b1;
				sink_wait--;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_word(input logic [kpd_pkg::OP_W-1:0] op_c,
		input logic [kpd_pkg::LINE_W-1:0] r, input logic [kpd_pkg::LINE_W-1:0] c);
		kpd_pkg::item_t w;
		int gap;
		gap = draw_gap();
		// Occasionally switch between idling and back-to-back traffic.
		if ($urandom_range(39, 0) == 0) begin
			steady = !steady;
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		op = op_c;
		row_lines = r;
		col_lines = c;
		in_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (in_stall);
		w.op = op_c;
		w.row_lines = r;
		w.col_lines = c;
		classifier.take_word(w);
		words_sent++;
	endtask

	// Waits until every report has come and the pipeline has drained.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (classifier.due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kpd_pkg::CFG_IDX_W-1:0] idx,
		input logic [kpd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		classifier.set_register(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(input int deb, input int hold);
		logic [kpd_pkg::CFG_DATA_W-1:0] val;
		logic [31:0] v;
		settle();
		// Upper bits of the debounce word are don't-care and get random values.
		v = $urandom_range(65535, 0);
		val = v[kpd_pkg::CFG_DATA_W-1:0];
		val[kpd_pkg::DEB_W-1:0] = deb[kpd_pkg::DEB_W-1:0];
		write_reg(kpd_pkg::REG_DEBOUNCE, val);
		write_reg(kpd_pkg::REG_HOLD, hold[kpd_pkg::CFG_DATA_W-1:0]);
		cur_deb = deb;
		cur_hold = hold;
	endtask

	// Press, ticks around the hold time, release and consume, with some disorder mixed in.
	task automatic press_sequence();
		logic [kpd_pkg::LINE_W-1:0] r;
		logic [kpd_pkg::LINE_W-1:0] c;
		logic [kpd_pkg::LINE_W-1:0] rr;
		logic [kpd_pkg::LINE_W-1:0] cc;
		int pre;
		int k;
		int extra;
		r = rand_lines(1);
		c = rand_lines(1);
		pre = cur_deb;
		if ($urandom_range(5, 0) == 0) begin
			pre = int'($urandom_range(cur_deb, 0));
		end
		repeat (pre) send_word(kpd_pkg::OP_TICK, rand_lines(0), rand_lines(0));
		send_word(kpd_pkg::OP_PAD, r, c);
		if ($urandom_range(1, 0) == 0) begin
			k = cur_hold + int'($urandom_range(2, 0));
		end else begin
			k = int'($urandom_range(cur_hold - 1, 0));
		end
		if (k > 40) begin
			k = int'($urandom_range(40, 0));
		end
		for (int i = 0; i < k; i++) begin
			if ($urandom_range(7, 0) == 0) begin
				send_word(kpd_pkg::OP_TICK, rand_lines(0), rand_lines(0));
			end else begin
				send_word(kpd_pkg::OP_TICK, r, c);
			end
		end
		if ($urandom_range(3, 0) == 0) begin
			send_word(kpd_pkg::OP_CONSUME, rand_lines(0), rand_lines(0));
		end
		extra = (cur_deb > k) ? cur_deb - k : 0;
		if ($urandom_range(5, 0) == 0) begin
			extra = 0;
		end
		repeat (extra) send_word(kpd_pkg::OP_TICK, r, c);
		case ($urandom_range(2, 0))
			0: begin
				rr = '0;
				cc = rand_lines(0);
			end
			1: begin
				rr = rand_lines(0);
				cc = '0;
			end
			default: begin
				rr = '0;
				cc = '0;
			end
		endcase
		send_word(kpd_pkg::OP_PAD, rr, cc);
		if ($urandom_range(3, 0) != 0) begin
			send_word(kpd_pkg::OP_CONSUME, rand_lines(0), rand_lines(0));
		end
	endtask

	task automatic run_phase(input int deb, input int hold, input int budget);
		int start;
		configure(deb, hold);
		start = words_sent;
		while (words_sent - start < budget) begin
			if ($urandom_range(4, 0) == 0) begin
				send_word(rand_op(), rand_lines(0), rand_lines(0));
			end else begin
				press_sequence();
			end
		end
	endtask

	initial begin
		classifier = new();
		steady = 1'b0;
		words_sent = 0;
		cur_deb = int'(kpd_pkg::DEBOUNCE_RESET);
		cur_hold = int'(kpd_pkg::HOLD_RESET);
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = kpd_pkg::OP_TICK;
		row_lines = '0;
		col_lines = '0;
		cfg_valid = 1'b0;
		cfg_index = kpd_pkg::REG_DEBOUNCE;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: nothing ready, and a pad right after reset falls inside the debounce window.
		send_word(kpd_pkg::OP_CONSUME, 3'd7, 3'd7);
		send_word(kpd_pkg::OP_PAD, 3'd7, 3'd7);
		send_word(OP_UNUSED, 3'd5, 3'd2);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);

		configure(0, 3);
		// Click, then an empty consume.
		send_word(kpd_pkg::OP_PAD, 3'd1, 3'd1);
		send_word(kpd_pkg::OP_PAD, 3'd0, 3'd0);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);
		// Hold of the largest key code.
		send_word(kpd_pkg::OP_PAD, 3'd7, 3'd7);
		repeat (3) send_word(kpd_pkg::OP_TICK, 3'd7, 3'd7);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);
		// Another key read when the timer expires drops the press.
		send_word(kpd_pkg::OP_PAD, 3'd4, 3'd2);
		repeat (3) send_word(kpd_pkg::OP_TICK, 3'd4, 3'd0);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);
		// A release after a hold leaves the hold pending.
		send_word(kpd_pkg::OP_PAD, 3'd3, 3'd5);
		repeat (3) send_word(kpd_pkg::OP_TICK, 3'd3, 3'd5);
		send_word(kpd_pkg::OP_PAD, 3'd0, 3'd6);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);
		// A new press replaces a pending click.
		send_word(kpd_pkg::OP_PAD, 3'd2, 3'd1);
		send_word(kpd_pkg::OP_PAD, 3'd5, 3'd0);
		send_word(kpd_pkg::OP_PAD, 3'd6, 3'd4);
		send_word(kpd_pkg::OP_PAD, 3'd7, 3'd0);
		send_word(kpd_pkg::OP_CONSUME, 3'd0, 3'd0);

		run_phase(0, 1, 180);
		run_phase(2, 5, 180);
		run_phase(6, 12, 180);
		run_phase(1, 24, 180);
		run_phase(int'($urandom_range(8, 0)), int'($urandom_range(30, 1)), 180);
		run_phase(255, 65535, 180);
		run_phase(0, 65535, 180);
		run_phase(3, 2, 180);

		settle();
		repeat (8) @(posedge clk);
		if (classifier.fails == 0 && classifier.due.size() == 0) begin
			$display("** keypad_matrix_press_hold_detector: PASSED **");
		end else begin
			$display("** keypad_matrix_press_hold_detector: FAILED **");
		end
		$finish;
	end

endmodule
